// ----- hw/rtl/kect_pkg.sv -----
// Package with the widths and the command, status and controller state codes of the keyed event counter table.
package kect_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CAT_IN_W = 3;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VALUE_W  = 22;
  localparam int unsigned STATUS_W = 2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 3'd0,
    CMD_CLEAR     = 3'd1,
    CMD_READ      = 3'd2,
    CMD_TGT_TOTAL = 3'd3,
    CMD_CAT_TOTAL = 3'd4,
    CMD_GRAND     = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_INCW,
    S_ZERO,
    S_SUM,
    S_DONE
  } state_e;

endpackage

// ----- hw/rtl/keyed_event_counter_table_top.sv -----
// Keyed event counter table: key lookup, saturating counters and sums over a counter memory.
//
// One item is handled at a time. After the input transfer, a lookup walks the key memory
// one entry per cycle. A push to a known key then does a read-modify-write of its counter;
// a push that creates an entry writes its CATEGORIES counters one per cycle. Sums read the
// counter memory one word per cycle, then add the last word and hand the sum on; category
// and grand totals read nothing when the table is empty. The result then moves from S_DONE
// to the output register once that is free; a new item is taken while a result still
// waits there. Invalid input goes straight to S_DONE. No memory clearing runs after reset.
module keyed_event_counter_table_top #(
  parameter int unsigned MAX_TARGETS  = 16,
  parameter int unsigned CATEGORIES   = 4,
  parameter int unsigned KEY_BYTES    = 8,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [kect_pkg::CMD_W-1:0]     command_i,
  input  logic [kect_pkg::CAT_IN_W-1:0]  category_i,
  input  logic [kect_pkg::KEY_W-1:0]     target_key_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [kect_pkg::VALUE_W-1:0]   value_o,
  output logic [kect_pkg::STATUS_W-1:0]  status_o
);
  import kect_pkg::*;

  localparam int unsigned IDX_W  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TARGETS + 1);
  localparam int unsigned CAT_W  = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
  localparam int unsigned ADDR_W = IDX_W + CAT_W;
  localparam int unsigned SUM_W  = ((COUNTER_BITS > VALUE_W) ? COUNTER_BITS : VALUE_W) + 1;

  localparam logic [CNT_W-1:0]        USED_FULL = CNT_W'(MAX_TARGETS);
  localparam logic [CAT_W-1:0]        CAT_LAST  = CAT_W'(CATEGORIES - 1);
  localparam logic [COUNTER_BITS-1:0] CTR_MAX   = {COUNTER_BITS{1'b1}};

  // Memories
  logic [KEY_W-1:0]        key_mem [MAX_TARGETS];
  logic [COUNTER_BITS-1:0] ctr_mem [2**ADDR_W];

  logic                    key_we;
  logic [IDX_W-1:0]        key_waddr;
  logic [IDX_W-1:0]        key_raddr;
  logic [KEY_W-1:0]        key_rdata_q;
  logic                    ctr_we;
  logic [ADDR_W-1:0]       ctr_waddr;
  logic [COUNTER_BITS-1:0] ctr_wdata;
  logic [ADDR_W-1:0]       ctr_raddr;
  logic [COUNTER_BITS-1:0] ctr_rdata_q;

  // Control and payload registers
  state_e                  state_q, state_d;
  cmd_e                    cmd_q, cmd_d;
  logic [CAT_IN_W-1:0]     cat_q, cat_d;
  logic [KEY_W-1:0]        key_q, key_d;
  logic [CNT_W-1:0]        used_q, used_d;
  logic [CNT_W-1:0]        scan_q, scan_d;
  logic                    pend_q, pend_d;
  logic [IDX_W-1:0]        hit_q, hit_d;
  logic [IDX_W-1:0]        sw_idx_q, sw_idx_d;
  logic [CAT_W-1:0]        sw_cat_q, sw_cat_d;
  logic                    step_cat_q, step_cat_d;
  logic                    step_idx_q, step_idx_d;
  logic                    iss_done_q, iss_done_d;
  logic [VALUE_W-1:0]      acc_q, acc_d;
  logic [VALUE_W-1:0]      res_value_q, res_value_d;
  status_e                 res_status_q, res_status_d;
  logic                    out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]      out_value_q, out_value_d;
  status_e                 out_status_q, out_status_d;

  logic [KEY_W-1:0]        norm_key;
  logic                    key_alive;
  logic                    in_xfer;
  logic                    cat_ok;
  logic                    key_ok;
  logic                    key_match;
  logic                    last_issue;
  logic [SUM_W-1:0]        sum_full;
  logic [VALUE_W-1:0]      sum_sat;
  logic [IDX_W-1:0]        used_idx;
  logic [CAT_W-1:0]        cat_sel;

  // Keep the characters before the first zero byte, at most KEY_BYTES of them.
  always_comb begin
    norm_key  = '0;
    key_alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i < KEY_BYTES && key_alive && target_key_i[8*i +: 8] != 8'd0) begin
        norm_key[8*i +: 8] = target_key_i[8*i +: 8];
      end else begin
        key_alive = 1'b0;
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cat_ok     = ({1'b0, category_i} < (CAT_IN_W + 1)'(CATEGORIES));
  assign key_ok     = (norm_key != '0);
  assign key_match  = (key_rdata_q == key_q);
  assign used_idx   = IDX_W'(used_q);
  assign cat_sel    = cat_q[CAT_W-1:0];

  assign last_issue = (!step_cat_q || sw_cat_q == CAT_LAST) &&
                      (!step_idx_q || (CNT_W'(sw_idx_q) + CNT_W'(1)) == used_q);

  // The running sum saturates at every step, which equals clamping the full sum.
  assign sum_full = SUM_W'(acc_q) + SUM_W'(ctr_rdata_q);
  assign sum_sat  = (sum_full > SUM_W'(VALUE_MAX)) ? VALUE_MAX : sum_full[VALUE_W-1:0];

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    cat_d        = cat_q;
    key_d        = key_q;
    used_d       = used_q;
    scan_d       = scan_q;
    pend_d       = pend_q;
    hit_d        = hit_q;
    sw_idx_d     = sw_idx_q;
    sw_cat_d     = sw_cat_q;
    step_cat_d   = step_cat_q;
    step_idx_d   = step_idx_q;
    iss_done_d   = iss_done_q;
    acc_d        = acc_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    key_we       = 1'b0;
    key_waddr    = used_idx;
    key_raddr    = scan_q[IDX_W-1:0];
    ctr_we       = 1'b0;
    ctr_waddr    = {hit_q, cat_sel};
    ctr_wdata    = '0;
    ctr_raddr    = {sw_idx_q, sw_cat_q};

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_d        = cmd_e'(command_i);
          cat_d        = category_i;
          key_d        = norm_key;
          scan_d       = '0;
          pend_d       = 1'b0;
          acc_d        = '0;
          res_value_d  = '0;
          res_status_d = ST_OK;
          sw_idx_d     = '0;
          sw_cat_d     = category_i[CAT_W-1:0];
          step_cat_d   = 1'b0;
          step_idx_d   = 1'b1;
          iss_done_d   = (used_q == '0);
          case (command_i) inside
            CMD_PUSH, CMD_CLEAR, CMD_READ: begin
              if (cat_ok && key_ok) begin
                state_d = S_LOOK;
              end else begin
                res_status_d = ST_INVALID;
                state_d      = S_DONE;
              end
            end
            CMD_TGT_TOTAL: begin
              if (key_ok) begin
                state_d = S_LOOK;
              end else begin
                res_status_d = ST_INVALID;
                state_d      = S_DONE;
              end
            end
            CMD_CAT_TOTAL: begin
              if (cat_ok) begin
                state_d = S_SUM;
              end else begin
                res_status_d = ST_INVALID;
                state_d      = S_DONE;
              end
            end
            CMD_GRAND: begin
              sw_cat_d   = '0;
              step_cat_d = 1'b1;
              state_d    = S_SUM;
            end
            default: begin
              res_status_d = ST_INVALID;
              state_d      = S_DONE;
            end
          endcase
        end
      end

      // Key search: the read issued last cycle is compared while the next one goes out.
      S_LOOK: begin
        if (pend_q && key_match) begin
          hit_d      = IDX_W'(scan_q - CNT_W'(1));
          pend_d     = 1'b0;
          sw_idx_d   = IDX_W'(scan_q - CNT_W'(1));
          step_idx_d = 1'b0;
          iss_done_d = 1'b0;
          case (cmd_q)
            CMD_PUSH: begin
              ctr_raddr = {IDX_W'(scan_q - CNT_W'(1)), cat_sel};
              state_d   = S_INCW;
            end
            CMD_CLEAR: begin
              ctr_we    = 1'b1;
              ctr_waddr = {IDX_W'(scan_q - CNT_W'(1)), cat_sel};
              ctr_wdata = '0;
              state_d   = S_DONE;
            end
            CMD_READ: begin
              sw_cat_d   = cat_sel;
              step_cat_d = 1'b0;
              state_d    = S_SUM;
            end
            default: begin
              sw_cat_d   = '0;
              step_cat_d = 1'b1;
              state_d    = S_SUM;
            end
          endcase
        end else if (scan_q == used_q) begin
          pend_d = 1'b0;
          if (cmd_q == CMD_PUSH) begin
            if (used_q == USED_FULL) begin
              res_status_d = ST_FULL;
              state_d      = S_DONE;
            end else begin
              key_we   = 1'b1;
              sw_cat_d = '0;
              state_d  = S_ZERO;
            end
          end else begin
            res_status_d = ST_NOT_FOUND;
            state_d      = S_DONE;
          end
        end else begin
          scan_d = scan_q + CNT_W'(1);
          pend_d = 1'b1;
        end
      end

      S_INCW: begin
        ctr_we    = 1'b1;
        ctr_wdata = (ctr_rdata_q == CTR_MAX) ? ctr_rdata_q : ctr_rdata_q + COUNTER_BITS'(1);
        state_d   = S_DONE;
      end

      // New entry: its counters are written in turn, the pushed one starting at one.
      S_ZERO: begin
        ctr_we    = 1'b1;
        ctr_waddr = {used_idx, sw_cat_q};
        ctr_wdata = (sw_cat_q == cat_sel) ? COUNTER_BITS'(1) : '0;
        if (sw_cat_q == CAT_LAST) begin
          used_d  = used_q + CNT_W'(1);
          state_d = S_DONE;
        end else begin
          sw_cat_d = sw_cat_q + CAT_W'(1);
        end
      end

      S_SUM: begin
        if (pend_q) begin
          acc_d = sum_sat;
        end
        if (!iss_done_q) begin
          pend_d     = 1'b1;
          iss_done_d = last_issue;
          if (step_cat_q && sw_cat_q != CAT_LAST) begin
            sw_cat_d = sw_cat_q + CAT_W'(1);
          end else begin
            if (step_cat_q) begin
              sw_cat_d = '0;
            end
            if (step_idx_q) begin
              sw_idx_d = sw_idx_q + IDX_W'(1);
            end
          end
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          res_value_d = acc_q;
          state_d     = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_valid_d  = 1'b1;
      out_value_d  = res_value_q;
      out_status_d = res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      scan_q       <= '0;
      pend_q       <= 1'b0;
      iss_done_q   <= 1'b0;
      step_cat_q   <= 1'b0;
      step_idx_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      scan_q       <= scan_d;
      pend_q       <= pend_d;
      iss_done_q   <= iss_done_d;
      step_cat_q   <= step_cat_d;
      step_idx_q   <= step_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    cat_q        <= cat_d;
    key_q        <= key_d;
    hit_q        <= hit_d;
    sw_idx_q     <= sw_idx_d;
    sw_cat_q     <= sw_cat_d;
    acc_q        <= acc_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_q;
    end
    key_rdata_q <= key_mem[key_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctr_we) begin
      ctr_mem[ctr_waddr] <= ctr_wdata;
    end
    ctr_rdata_q <= ctr_mem[ctr_raddr];
  end

endmodule
